>>> design/bilinear_image_scaler_unit_macros.svh
// assertion macros for the bilinear image scaler
// used by modules that check their own control state; expects aclk and aresetn in scope
`ifndef BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH

// same-cycle implication
`define BIS_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("bis check failed");

// next-cycle implication
`define BIS_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("bis check failed");

`endif

>>> design/bis_pkg.sv
// types and constants for the bilinear image scaler
// no dependencies
package bis_pkg;

    localparam int COORD_W     = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] REG_SOURCE_WIDTH  = 8'd0;
    localparam logic [7:0] REG_SOURCE_HEIGHT = 8'd1;
    localparam logic [7:0] REG_COLUMN_STEP   = 8'd2;
    localparam logic [7:0] REG_ROW_STEP      = 8'd3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [9:0] column;
        logic [9:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [9:0] out_column;
        logic [9:0] out_row;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0] xlast;
        logic [COORD_W-1:0] ylast;
        logic [25:0]        col_step;
        logic [25:0]        row_step;
    } cfg_t;

    typedef struct packed {
        logic               is_req;
        logic               wr_en;
        logic [9:0]         col;
        logic [9:0]         row;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] y2;
        logic [7:0]         fx;
        logic [7:0]         fy;
        logic [23:0]        pix;
    } job_t;

endpackage

>>> design/bis_queue.sv
// four-entry job queue between the front and back of the scaler
// depends on bis_pkg and the assertion macro header
`include "bilinear_image_scaler_unit_macros.svh"
module bis_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bis_pkg::job_t push_job,
    input  logic          pop,
    output bis_pkg::job_t head_job,
    output logic          not_empty,
    output logic          full
);
    import bis_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head_job  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `BIS_ASSERT_NOW(q_count_bounded, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `BIS_ASSERT_NOW(q_no_push_full, push, !full || pop)
    `BIS_ASSERT_NOW(q_no_pop_empty, pop, count_reg != '0)
    `BIS_ASSERT_NEXT(q_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)
endmodule

>>> design/bis_front.sv
// front of the scaler: accepts beats, scales coordinates, clamps to the source edge
// depends on bis_pkg; feeds bis_queue
module bis_front #(
    parameter int MAX_SOURCE_WIDTH  = 1024,
    parameter int MAX_SOURCE_HEIGHT = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bis_pkg::in_t  s_data,
    input  bis_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          push,
    output bis_pkg::job_t push_job
);
    import bis_pkg::*;

    logic        f1_valid_reg;
    in_t         f1_data_reg;
    logic [35:0] px_reg;
    logic [35:0] py_reg;

    logic [19:0]        xint, yint;
    logic [COORD_W-1:0] cx1, cx2, cy1, cy2;
    logic               load_ok;

    assign s_ready = !f1_valid_reg || !q_full;
    assign push    = f1_valid_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            f1_valid_reg <= 1'b1;
        end else if (push) begin
            f1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f1_data_reg <= s_data;
            px_reg      <= 36'(s_data.column) * 36'(cfg.col_step);
            py_reg      <= 36'(s_data.row) * 36'(cfg.row_step);
        end
    end

    always_comb begin
        xint    = px_reg[35:16];
        yint    = py_reg[35:16];
        cx1     = (xint > 20'(cfg.xlast)) ? cfg.xlast : xint[COORD_W-1:0];
        cy1     = (yint > 20'(cfg.ylast)) ? cfg.ylast : yint[COORD_W-1:0];
        cx2     = (cx1 < cfg.xlast) ? cx1 + 1'b1 : cx1;
        cy2     = (cy1 < cfg.ylast) ? cy1 + 1'b1 : cy1;
        load_ok = (32'(f1_data_reg.column) < MAX_SOURCE_WIDTH) &&
                  (32'(f1_data_reg.row) < MAX_SOURCE_HEIGHT);

        push_job.is_req = (f1_data_reg.operation == OP_REQUEST);
        push_job.wr_en  = (f1_data_reg.operation == OP_LOAD) && load_ok;
        push_job.col    = f1_data_reg.column;
        push_job.row    = f1_data_reg.row;
        push_job.fx     = px_reg[15:8];
        push_job.fy     = py_reg[15:8];
        push_job.pix    = {f1_data_reg.red_in, f1_data_reg.green_in, f1_data_reg.blue_in};
        if (f1_data_reg.operation == OP_LOAD) begin
            push_job.x1 = COORD_W'(f1_data_reg.column);
            push_job.x2 = COORD_W'(f1_data_reg.column);
            push_job.y1 = COORD_W'(f1_data_reg.row);
            push_job.y2 = COORD_W'(f1_data_reg.row);
        end else begin
            push_job.x1 = cx1;
            push_job.x2 = cx2;
            push_job.y1 = cy1;
            push_job.y2 = cy2;
        end
    end
endmodule

>>> design/bis_back.sv
// back of the scaler: four parity banks of the frame store and the interpolation pipe
// depends on bis_pkg; pulls jobs from bis_queue
module bis_back #(
    parameter int MAX_SOURCE_WIDTH  = 1024,
    parameter int MAX_SOURCE_HEIGHT = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  bis_pkg::job_t head_job,
    input  logic          q_not_empty,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output bis_pkg::out_t m_data
);
    import bis_pkg::*;

    localparam int XB         = $clog2(MAX_SOURCE_WIDTH);
    localparam int YB         = $clog2(MAX_SOURCE_HEIGHT);
    localparam int HXB        = (XB > 1) ? XB - 1 : 1;
    localparam int HYB        = (YB > 1) ? YB - 1 : 1;
    localparam int BANK_DEPTH = 2 ** (HXB + HYB);

    logic adv;

    logic [COORD_W-1:0] xe, xo, ye, yo;
    logic [HXB-1:0]     xa [2];
    logic [HYB-1:0]     ya [2];
    logic [HXB-1:0]     wxa;
    logic [HYB-1:0]     wya;
    logic [1:0]         wbank;

    logic [23:0] rd_data_reg [4];

    logic       b_valid_reg;
    logic [9:0] b_col_reg, b_row_reg;
    logic       b_px1_reg, b_px2_reg, b_py1_reg, b_py2_reg;
    logic [7:0] b_fx_reg, b_fy_reg;

    logic [23:0] p11, p12, p21, p22;
    logic [8:0]  wx0;
    logic [16:0] t0 [3];
    logic [16:0] t1 [3];

    logic        c_valid_reg;
    logic [9:0]  c_col_reg, c_row_reg;
    logic [7:0]  c_fy_reg;
    logic [16:0] c_t0_reg [3];
    logic [16:0] c_t1_reg [3];

    logic [8:0]  wy0;
    logic [25:0] acc [3];

    logic m_valid_reg;
    out_t m_data_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign pop     = adv && q_not_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // bank addresses: even and odd column / row halves
    always_comb begin
        xe    = head_job.x1[0] ? head_job.x2 : head_job.x1;
        xo    = head_job.x1[0] ? head_job.x1 : head_job.x2;
        ye    = head_job.y1[0] ? head_job.y2 : head_job.y1;
        yo    = head_job.y1[0] ? head_job.y1 : head_job.y2;
        xa[0] = HXB'(xe >> 1);
        xa[1] = HXB'(xo >> 1);
        ya[0] = HYB'(ye >> 1);
        ya[1] = HYB'(yo >> 1);
        wxa   = HXB'(head_job.x1 >> 1);
        wya   = HYB'(head_job.y1 >> 1);
        wbank = {head_job.y1[0], head_job.x1[0]};
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [23:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (pop && head_job.wr_en && (wbank == 2'(g))) begin
                bank_mem[{wya, wxa}] <= head_job.pix;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rd_data_reg[g] <= bank_mem[{ya[g / 2], xa[g % 2]}];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= pop && head_job.is_req;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_col_reg <= head_job.col;
            b_row_reg <= head_job.row;
            b_px1_reg <= head_job.x1[0];
            b_px2_reg <= head_job.x2[0];
            b_py1_reg <= head_job.y1[0];
            b_py2_reg <= head_job.y2[0];
            b_fx_reg  <= head_job.fx;
            b_fy_reg  <= head_job.fy;
        end
    end

    // horizontal blend
    always_comb begin
        p11 = rd_data_reg[{b_py1_reg, b_px1_reg}];
        p12 = rd_data_reg[{b_py1_reg, b_px2_reg}];
        p21 = rd_data_reg[{b_py2_reg, b_px1_reg}];
        p22 = rd_data_reg[{b_py2_reg, b_px2_reg}];
        wx0 = 9'd256 - 9'(b_fx_reg);
        for (int c = 0; c < 3; c++) begin
            t0[c] = 17'(p11[23 - 8 * c -: 8]) * 17'(wx0) +
                    17'(p12[23 - 8 * c -: 8]) * 17'(b_fx_reg);
            t1[c] = 17'(p21[23 - 8 * c -: 8]) * 17'(wx0) +
                    17'(p22[23 - 8 * c -: 8]) * 17'(b_fx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_col_reg <= b_col_reg;
            c_row_reg <= b_row_reg;
            c_fy_reg  <= b_fy_reg;
            c_t0_reg  <= t0;
            c_t1_reg  <= t1;
        end
    end

    // vertical blend
    always_comb begin
        wy0 = 9'd256 - 9'(c_fy_reg);
        for (int c = 0; c < 3; c++) begin
            acc[c] = 26'(c_t0_reg[c]) * 26'(wy0) + 26'(c_t1_reg[c]) * 26'(c_fy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.out_column <= c_col_reg;
            m_data_reg.out_row    <= c_row_reg;
            m_data_reg.red_out    <= acc[0][23:16];
            m_data_reg.green_out  <= acc[1][23:16];
            m_data_reg.blue_out   <= acc[2][23:16];
        end
    end
endmodule

>>> design/bilinear_image_scaler_unit.sv
// bilinear RGB888 image scaler, top level with configuration registers
// depends on bis_pkg, bis_front, bis_queue, bis_back
//
// s_ channel: one beat per item. operation load writes a source pixel into the
// frame store, operation request asks for one output pixel at (column, row).
// m_ channel: one beat per request carrying the echoed coordinates and the
// interpolated red, green and blue. loads give no beat.
// cfg channel: cfg_index selects source width, source height, column step or
// row step (Q10.16); writes are taken every cycle. the user must write only
// while the block is idle; the block does not enforce this. throughput: one
// item per cycle while s_ready is high, set by the four column/row parity banks
// of the frame store, which give all four neighbours in one read. a request
// passes the front register, the queue and back registers b, c and m. a load is
// visible to any request accepted after it. reset clears the pipeline, the
// queue and the registers to width and height 1024 and steps of 1.0; the frame
// store is undefined until written. when m_ready is low with m_valid high the
// back pipe holds, the four-entry queue fills, and s_ready then drops.
module bilinear_image_scaler_unit #(
    parameter int MAX_SOURCE_WIDTH  = 1024,
    parameter int MAX_SOURCE_HEIGHT = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bis_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bis_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import bis_pkg::*;

    logic [10:0] src_width_reg;
    logic [10:0] src_height_reg;
    logic [25:0] col_step_reg;
    logic [25:0] row_step_reg;
    cfg_t        cfg;

    logic push, pop, q_full, q_not_empty;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= 11'd1024;
            src_height_reg <= 11'd1024;
            col_step_reg   <= 26'd65536;
            row_step_reg   <= 26'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_width_reg  <= cfg_data[10:0];
                REG_SOURCE_HEIGHT: src_height_reg <= cfg_data[10:0];
                REG_COLUMN_STEP:   col_step_reg   <= cfg_data[25:0];
                REG_ROW_STEP:      row_step_reg   <= cfg_data[25:0];
                default: ;
            endcase
        end
    end

    // last column and row in use
    always_comb begin
        if (src_width_reg == '0) begin
            cfg.xlast = '0;
        end else if (32'(src_width_reg) > MAX_SOURCE_WIDTH) begin
            cfg.xlast = COORD_W'(MAX_SOURCE_WIDTH - 1);
        end else begin
            cfg.xlast = COORD_W'(src_width_reg - 11'd1);
        end
        if (src_height_reg == '0) begin
            cfg.ylast = '0;
        end else if (32'(src_height_reg) > MAX_SOURCE_HEIGHT) begin
            cfg.ylast = COORD_W'(MAX_SOURCE_HEIGHT - 1);
        end else begin
            cfg.ylast = COORD_W'(src_height_reg - 11'd1);
        end
        cfg.col_step = col_step_reg;
        cfg.row_step = row_step_reg;
    end

    bis_front #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_full  (q_full),
        .push    (push),
        .push_job(push_job)
    );

    bis_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .not_empty(q_not_empty),
        .full     (q_full)
    );

    bis_back #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .q_not_empty(q_not_empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );
endmodule

>>> verif/bilinear_image_scaler_unit_test.sv
// self-checking testbench for bilinear_image_scaler_unit: loads, requests and register writes
// depends on bis_pkg and the bilinear_image_scaler_unit rtl
module bilinear_image_scaler_unit_test;
    import bis_pkg::*;

    localparam int STORE_W   = 1024;
    localparam int STORE_H   = 1024;
    localparam int MAX_WAIT  = 400000;

    typedef struct {
        in_t         item;
        bit          typed;
        logic [23:0] rgb;
    } dir_row_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // scaler state kept alongside the block
    logic [23:0] frame_pix [int];
    logic [10:0] width_reg, height_reg;
    logic [25:0] col_step_reg, row_step_reg;

    out_t pixel_queue [$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   send_idle = 18;
    int   recv_idle = 58;
    dir_row_t dir_rows [$];

    bilinear_image_scaler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int size_used(logic [10:0] r, int lim);
        if (r == 0) return 1;
        return (r > lim) ? lim : int'(r);
    endfunction

    function automatic void neighbours(input logic [9:0] c, input logic [9:0] r,
                                       output int x1, output int x2, output int y1,
                                       output int y2, output int fx, output int fy);
        longint unsigned px, py;
        int w, h;
        w  = size_used(width_reg, STORE_W);
        h  = size_used(height_reg, STORE_H);
        px = longint'(c) * longint'(col_step_reg);
        py = longint'(r) * longint'(row_step_reg);
        x1 = ((px >> 16) > w - 1) ? w - 1 : int'(px >> 16);
        y1 = ((py >> 16) > h - 1) ? h - 1 : int'(py >> 16);
        x2 = (x1 < w - 1) ? x1 + 1 : x1;
        y2 = (y1 < h - 1) ? y1 + 1 : y1;
        fx = int'((px >> 8) & 8'hff);
        fy = int'((py >> 8) & 8'hff);
    endfunction

    function automatic bit all_written(logic [9:0] c, logic [9:0] r);
        int x1, x2, y1, y2, fx, fy;
        neighbours(c, r, x1, x2, y1, y2, fx, fy);
        return frame_pix.exists(y1 * STORE_W + x1) && frame_pix.exists(y1 * STORE_W + x2)
            && frame_pix.exists(y2 * STORE_W + x1) && frame_pix.exists(y2 * STORE_W + x2);
    endfunction

    function automatic out_t interpolate(in_t it);
        int x1, x2, y1, y2, fx, fy, sh;
        logic [23:0] p11, p12, p21, p22;
        int unsigned acc;
        out_t o;
        neighbours(it.column, it.row, x1, x2, y1, y2, fx, fy);
        p11 = frame_pix[y1 * STORE_W + x1];
        p12 = frame_pix[y1 * STORE_W + x2];
        p21 = frame_pix[y2 * STORE_W + x1];
        p22 = frame_pix[y2 * STORE_W + x2];
        o.out_column = it.column;
        o.out_row    = it.row;
        for (int ch = 0; ch < 3; ch++) begin
            sh  = 16 - 8 * ch;
            acc = ((p11 >> sh) & 8'hff) * (256 - fx) * (256 - fy)
                + ((p12 >> sh) & 8'hff) * fx * (256 - fy)
                + ((p21 >> sh) & 8'hff) * (256 - fx) * fy
                + ((p22 >> sh) & 8'hff) * fx * fy;
            case (ch)
                0: o.red_out   = acc[23:16];
                1: o.green_out = acc[23:16];
                default: o.blue_out = acc[23:16];
            endcase
        end
        return o;
    endfunction

    // drive one item, update the model at its accepting edge
    task automatic send_item(in_t it, bit typed, logic [23:0] rgb);
        out_t o;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.operation == OP_LOAD) begin
            frame_pix[int'(it.row) * STORE_W + int'(it.column)] =
                {it.red_in, it.green_in, it.blue_in};
        end else begin
            o = interpolate(it);
            if (typed) {o.red_out, o.green_out, o.blue_out} = rgb;
            pixel_queue.push_back(o);
        end
    endtask

    task automatic load_pixel(int c, int r);
        in_t it;
        it.operation = OP_LOAD;
        it.column = 10'(c);
        it.row = 10'(r);
        {it.red_in, it.green_in, it.blue_in} = 24'($urandom);
        send_item(it, 1'b0, '0);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  width_reg    = val[10:0];
            REG_SOURCE_HEIGHT: height_reg   = val[10:0];
            REG_COLUMN_STEP:   col_step_reg = val[25:0];
            REG_ROW_STEP:      row_step_reg = val[25:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // one setting: grid of loads near both edges, then requests on written pixels
    task automatic run_phase(int w, int h, int cs, int rs, int n_req);
        int cols [$], rows [$], wu, hu;
        in_t it;
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        write_reg(REG_COLUMN_STEP, cs);
        write_reg(REG_ROW_STEP, rs);
        wu = size_used(11'(w), STORE_W);
        hu = size_used(11'(h), STORE_H);
        for (int i = 0; i < wu && i < 6; i++) cols.push_back(i);
        if (wu > 6) begin cols.push_back(wu - 2); cols.push_back(wu - 1); end
        for (int i = 0; i < hu && i < 6; i++) rows.push_back(i);
        if (hu > 6) begin rows.push_back(hu - 2); rows.push_back(hu - 1); end
        foreach (rows[j]) foreach (cols[i]) load_pixel(cols[i], rows[j]);
        for (int n = 0; n < n_req; n++) begin
            if ($urandom_range(9) == 0) begin
                load_pixel($urandom_range(1023), $urandom_range(1023));
            end
            it = in_t'(45'({$urandom, $urandom}));
            it.operation = OP_REQUEST;
            for (int t = 0; t < 40; t++) begin
                it.column = 10'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                         : $urandom_range(15));
                it.row    = 10'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                         : $urandom_range(15));
                if (all_written(it.column, it.row)) break;
                it.column = 0;
                it.row = 0;
            end
            send_item(it, 1'b0, '0);
        end
        drain();
    endtask

    function automatic void add_row(bit op, int c, int r, logic [23:0] pix, int typed,
                                    logic [23:0] rgb);
        dir_row_t d;
        d.item.operation = op;
        d.item.column = 10'(c);
        d.item.row = 10'(r);
        {d.item.red_in, d.item.green_in, d.item.blue_in} = pix;
        d.typed = (typed != 0);
        d.rgb = rgb;
        dir_rows.push_back(d);
    endfunction

    // result channel: backpressure and checking
    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", m_data);
            end else begin
                e = pixel_queue.pop_front();
                if (m_data.out_column !== e.out_column || m_data.out_row !== e.out_row
                        || m_data.red_out !== e.red_out || m_data.green_out !== e.green_out
                        || m_data.blue_out !== e.blue_out) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", e, m_data);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_WAIT) begin
            $display("bilinear_image_scaler_unit_test failed");
            $finish;
        end
    end

    initial begin
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        col_step_reg = 26'd65536;
        row_step_reg = 26'd65536;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(OP_LOAD, 0, 0, 24'h123456, 0, '0);
        add_row(OP_LOAD, 1, 0, 24'hffffff, 0, '0);
        add_row(OP_LOAD, 0, 1, 24'h000000, 0, '0);
        add_row(OP_LOAD, 1, 1, 24'h804020, 0, '0);
        add_row(OP_LOAD, 1023, 1023, 24'hffffff, 0, '0);
        add_row(OP_LOAD, 1022, 1023, 24'h00ff00, 0, '0);
        add_row(OP_LOAD, 1023, 1022, 24'hff00ff, 0, '0);
        add_row(OP_LOAD, 1022, 1022, 24'haa550f, 0, '0);
        add_row(OP_REQUEST, 0, 0, 24'hffffff, 1, 24'h123456);
        add_row(OP_REQUEST, 1023, 1023, 24'h000000, 1, 24'hffffff);
        add_row(OP_REQUEST, 1022, 1022, 24'h5a5a5a, 1, 24'haa550f);
        add_row(OP_REQUEST, 1022, 1023, 24'h000000, 1, 24'h00ff00);
        add_row(OP_REQUEST, 1023, 1022, 24'h000000, 1, 24'hff00ff);
        add_row(OP_LOAD, 1023, 0, 24'h000000, 0, '0);
        add_row(OP_LOAD, 0, 1023, 24'hffffff, 0, '0);
        add_row(OP_LOAD, 341, 682, 24'h5555aa, 0, '0);
        add_row(OP_LOAD, 682, 341, 24'haaaa55, 0, '0);
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rgb);
        drain();

        // half-pixel steps exercise nonzero weights
        run_phase(1024, 1024, 32768, 32768, 20);
        write_reg(8'd4, 32'hffffffff);
        write_reg(8'd255, 32'd0);

        run_phase(8, 6, 35289, 36409, 60);
        run_phase(0, 0, 3 << 16, 0, 30);
        run_phase(2047, 2047, 0, 0, 40);
        send_idle = 58;
        recv_idle = 18;
        run_phase(1024, 1024, 67043328, 67043328, 40);
        run_phase(5, 3, $urandom_range(65536), $urandom_range(65536), 80);
        run_phase(16, 9, $urandom_range(200000), $urandom_range(200000), 80);
        send_idle = 0;
        recv_idle = 0;
        run_phase(1, 1, $urandom, $urandom, 30);
        run_phase(12, 12, $urandom_range(65536), $urandom_range(65536), 40);
        drain();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && pixel_queue.size() == 0) begin
            $display("bilinear_image_scaler_unit_test passed");
        end else begin
            $display("bilinear_image_scaler_unit_test failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/bis_pkg.sv
design/bis_queue.sv
design/bis_front.sv
design/bis_back.sv
design/bilinear_image_scaler_unit.sv
verif/bilinear_image_scaler_unit_test.sv
